// ===== design/esd_pkg.sv =====
// esd_pkg: shared types, character constants and the hex-pair evaluator for
// the escape sequence decoder. No dependencies.
`timescale 1ns / 1ps

package esd_pkg;

   // Characters the decoder recognizes
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] BYTE_TAB    = 8'h09;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_CR     = 8'h0D;

   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_of_string;
      logic       last_of_string;
      logic       quoted_frame;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_string;
   } rsp_type;

   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_BSLASH = 4'b0010,
      MODE_HEX0   = 4'b0100,
      MODE_HEX1   = 4'b1000
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] held;
      logic       strip;
   } dec_state_type;

   // Results of one transaction, entry 0 goes out first
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] ent;
      logic [CNT_W-1:0]          cnt;
   } bundle_type;

   // {is_digit, value}
   function automatic logic [4:0] hex_digit(logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   // Base-16 parse of two bytes: optional whitespace or sign, up to two digits
   function automatic logic [7:0] hex_value(logic [7:0] c1, logic [7:0] c2);
      logic [4:0] d1;
      logic [4:0] d2;
      logic [7:0] r;
      d1 = hex_digit(c1);
      d2 = hex_digit(c2);
      r  = 8'h00;
      if (d1[4]) begin
         r = d2[4] ? {d1[3:0], d2[3:0]} : {4'h0, d1[3:0]};
      end else if (c1 == CHAR_SPACE || (c1 >= 8'd9 && c1 <= 8'd13) || c1 == CHAR_PLUS) begin
         r = d2[4] ? {4'h0, d2[3:0]} : 8'h00;
      end else if (c1 == CHAR_MINUS) begin
         r = d2[4] ? 8'(8'h00 - {4'h0, d2[3:0]}) : 8'h00;
      end
      return r;
   endfunction

endpackage

// ===== design/esd_decode.sv =====
// esd_decode: next-state and result logic for one input transaction.
// Depends on esd_pkg.
`timescale 1ns / 1ps

module esd_decode (
   input  esd_pkg::req_type       item,
   input  esd_pkg::dec_state_type cur,
   output esd_pkg::dec_state_type nxt,
   output esd_pkg::bundle_type    bundle
);
   import esd_pkg::*;

   always_comb begin
      mode_type         m;
      logic [7:0]       held;
      logic             strip;
      logic             drop;
      logic [7:0]       b;
      logic [7:0]       bytes_v [MAX_RESULTS];
      logic [CNT_W-1:0] n;

      b     = item.in_byte;
      m     = item.first_of_string ? MODE_NORMAL : cur.mode;
      held  = item.first_of_string ? 8'h00 : cur.held;
      strip = item.first_of_string ? (item.quoted_frame && !item.last_of_string) : cur.strip;
      drop  = strip && (item.first_of_string || item.last_of_string);
      n     = '0;
      for (int i = 0; i < MAX_RESULTS; i++) bytes_v[i] = 8'h00;

      if (!drop) begin
         unique case (m)
            MODE_NORMAL: begin
               if (b == CHAR_BSLASH) m = MODE_BSLASH;
               else begin
                  bytes_v[n] = b;
                  n = n + 1'b1;
               end
            end
            MODE_BSLASH: begin
               m = MODE_NORMAL;
               unique case (b)
                  CHAR_N:      begin bytes_v[n] = BYTE_LF;     n = n + 1'b1; end
                  CHAR_R:      begin bytes_v[n] = BYTE_CR;     n = n + 1'b1; end
                  CHAR_T:      begin bytes_v[n] = BYTE_TAB;    n = n + 1'b1; end
                  CHAR_BSLASH: begin bytes_v[n] = CHAR_BSLASH; n = n + 1'b1; end
                  CHAR_DQUOTE: begin bytes_v[n] = CHAR_DQUOTE; n = n + 1'b1; end
                  CHAR_SQUOTE: begin bytes_v[n] = CHAR_SQUOTE; n = n + 1'b1; end
                  CHAR_ZERO:   begin bytes_v[n] = BYTE_NUL;    n = n + 1'b1; end
                  CHAR_X:      m = MODE_HEX0;
                  default: begin
                     // unknown escape: keep the backslash, pass the byte
                     bytes_v[0] = CHAR_BSLASH;
                     bytes_v[1] = b;
                     n = 2'd2;
                  end
               endcase
            end
            MODE_HEX0: begin
               held = b;
               m    = MODE_HEX1;
            end
            MODE_HEX1: begin
               bytes_v[n] = hex_value(held, b);
               n = n + 1'b1;
               m = MODE_NORMAL;
            end
            default: m = MODE_NORMAL;
         endcase
      end

      // end of string: flush an escape cut short
      if (item.last_of_string) begin
         if (m == MODE_BSLASH) begin
            bytes_v[n] = CHAR_BSLASH;
            n = n + 1'b1;
         end else if (m == MODE_HEX0) begin
            bytes_v[0] = CHAR_BSLASH;
            bytes_v[1] = CHAR_X;
            n = 2'd2;
         end else if (m == MODE_HEX1) begin
            bytes_v[0] = CHAR_BSLASH;
            bytes_v[1] = CHAR_X;
            bytes_v[2] = held;
            n = 2'd3;
         end
         m     = MODE_NORMAL;
         strip = 1'b0;
         held  = 8'h00;
      end

      nxt.mode  = m;
      nxt.held  = held;
      nxt.strip = strip;

      for (int i = 0; i < MAX_RESULTS; i++) begin
         bundle.ent[i].out_byte      = bytes_v[i];
         bundle.ent[i].byte_valid    = 1'b1;
         bundle.ent[i].end_of_string = item.last_of_string && (CNT_W'(i + 1) == n);
      end
      bundle.cnt = n;

      // bare end marker
      if (item.last_of_string && n == '0) begin
         bundle.ent[0].out_byte      = 8'h00;
         bundle.ent[0].byte_valid    = 1'b0;
         bundle.ent[0].end_of_string = 1'b1;
         bundle.cnt                  = CNT_W'(1);
      end
   end

endmodule

// ===== design/escape_sequence_decoder.sv =====
// escape_sequence_decoder: top level, input register, decode, result queue.
// Depends on esd_pkg and esd_decode.
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | esd_pkg::req_type (one raw byte)
// rsp     | out       | rsp_valid/rsp_stall | esd_pkg::rsp_type (one decoded byte)
//
// An item producing one result passes the input register and then the
// result queue; items stream at one per cycle while rsp_stall is low. An
// item producing k results holds the queue until all k are popped; the rate
// is set by the queue draining one result per cycle. Synchronous active-high
// reset returns the decoder to normal mode, empties the input register and
// the result queue. rsp_stall backs up into the queue, then into req_stall;
// an empty input register still takes an item while the queue has results.

module escape_sequence_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  esd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output esd_pkg::rsp_type rsp_data
);
   import esd_pkg::*;

   // input register
   logic          in_valid_ff, in_valid_in;
   req_type       in_ff;

   // decoder state
   dec_state_type st_ff, st_in;

   // result queue, entry 0 is at the output
   rsp_type [MAX_RESULTS-1:0] q_ff, q_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   dec_state_type st_next;
   bundle_type    bundle;
   logic          pop, queue_free, load, accept;

   esd_decode u_decode (
      .item   (in_ff),
      .cur    (st_ff),
      .nxt    (st_next),
      .bundle (bundle)
   );

   assign rsp_valid  = (cnt_ff != '0);
   assign rsp_data   = q_ff[0];
   assign pop        = rsp_valid && !rsp_stall;
   // queue can take a new bundle when empty or emptying this cycle
   assign queue_free = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && pop);
   assign load       = in_valid_ff && queue_free;
   assign req_stall  = in_valid_ff && !queue_free;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) in_valid_in = 1'b0;
      if (accept) in_valid_in = 1'b1;

      st_in = load ? st_next : st_ff;

      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) q_in[i] = q_ff[i+1];
         cnt_in = cnt_ff - 1'b1;
      end
      if (load) begin
         q_in   = bundle.ent;
         cnt_in = bundle.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         st_ff.mode  <= MODE_NORMAL;
         st_ff.held  <= 8'h00;
         st_ff.strip <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         st_ff       <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_ff <= req_data;
      q_ff <= q_in;
   end

   // end marker only on the last queued result
   a_eos_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_string |-> cnt_ff == CNT_W'(1))
      else $error("end_of_string before last queued result");

   // an empty byte only as a bare end marker
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.end_of_string)
      else $error("invalid byte without end_of_string");

   // a last byte always yields at least one result
   a_last_yields: assert property (@(posedge clock) disable iff (reset)
      load && in_ff.last_of_string |=> rsp_valid)
      else $error("last byte produced no result");

   // stall only while holding an item
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid)
      else $error("input stalled without backlog");

endmodule
